### design/rfd_pkg.sv
// Package for the report frame deframer: status and function codes,
// register indexes and sizing constants used by the deframer top module.
// No dependencies.
package rfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int HDR_BYTES       = 4;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 64;

    typedef enum logic [2:0] {
        ST_AGAIN    = 3'd0,
        ST_OK       = 3'd1,
        ST_OVERSIZE = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_READ     = 3'd4
    } t_status;

    localparam logic [1:0] FN_REPORT = 2'd0;
    localparam logic [1:0] FN_RAW    = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    localparam logic [1:0] REG_TYPE_MASK    = 2'd0;
    localparam logic [1:0] REG_PAD_BYTE     = 2'd1;
    localparam logic [1:0] REG_START_MARKER = 2'd2;

    localparam logic [63:0] TYPE_MASK_RST    = 64'd0;
    localparam logic [7:0]  PAD_BYTE_RST     = 8'd0;
    localparam logic [7:0]  START_MARKER_RST = 8'd1;

endpackage

### design/rfd_store.sv
// Payload store of the report frame deframer: one write port, one read
// port with registered data and write-to-read forwarding. No package use.
module rfd_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/report_frame_deframer.sv
// Report frame deframer: an item passes the input register, then the result
// register. One item is taken every cycle while o_stall is low; the store's
// registered read port sets the stage between the input and result registers.
// Synchronous active-low reset clears control state and sets the registers
// to their defaults; the payload store is not cleared and needs no sweep.
// Depends on rfd_pkg and rfd_store.
module report_frame_deframer #(
    parameter int MAX_PAYLOAD = rfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rfd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rfd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_first_of_report,
    input  logic                         i_last_of_report,
    input  logic [9:0]                   i_read_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_frame_type,
    output logic [7:0]                   o_frame_flags,
    output logic [10:0]                  o_payload_length,
    output logic [7:0]                   o_read_data,
    output logic [31:0]                  o_resync_count
);

    localparam int HDR        = rfd_pkg::HDR_BYTES;
    localparam int STORE_SIZE = HDR + MAX_PAYLOAD;
    localparam int FW         = $clog2(STORE_SIZE + 1);
    localparam int AW         = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef logic [FW-1:0] t_fill;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_SKIP   = 2'd1,
        PH_TAIL   = 2'd2
    } t_phase;

    typedef struct packed {
        rfd_pkg::t_status rc;
        t_fill            fill;
        logic             set_done;
        logic             wr;
        logic [3:0][7:0]  hdr;
    } t_push;

    function automatic t_push push_byte(input t_fill fill, input logic [3:0][7:0] hdr,
                                        input logic [7:0] b, input logic [63:0] mask,
                                        input logic [7:0] pad);
        t_push       p;
        t_fill       nf;
        logic [15:0] len;
        p.rc       = rfd_pkg::ST_AGAIN;
        p.fill     = fill;
        p.set_done = 1'b0;
        p.wr       = 1'b0;
        p.hdr      = hdr;
        nf         = fill + t_fill'(1);
        if ((fill == '0) && (b == pad)) begin
            p.fill = fill;
        end else if (32'(fill) >= 32'(STORE_SIZE)) begin
            p.fill = '0;
        end else begin
            p.wr = 1'b1;
            if (32'(fill) < 32'(HDR)) begin
                p.hdr[fill[1:0]] = b;
            end
            p.fill = nf;
            if (32'(nf) >= 32'(HDR)) begin
                len = {p.hdr[3], p.hdr[2]};
                if (32'(len) > 32'(MAX_PAYLOAD)) begin
                    p.rc   = rfd_pkg::ST_OVERSIZE;
                    p.fill = '0;
                end else if ((p.hdr[0] >= 8'd64) || !mask[p.hdr[0][5:0]]) begin
                    p.rc   = rfd_pkg::ST_UNKNOWN;
                    p.fill = '0;
                end else if (32'(nf) == 32'(len) + 32'(HDR)) begin
                    p.rc       = rfd_pkg::ST_OK;
                    p.set_done = 1'b1;
                end
            end
        end
        return p;
    endfunction

    // configuration
    logic [63:0] r_type_mask;
    logic [7:0]  r_pad_byte;
    logic [7:0]  r_start_marker;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_mask    <= rfd_pkg::TYPE_MASK_RST;
            r_pad_byte     <= rfd_pkg::PAD_BYTE_RST;
            r_start_marker <= rfd_pkg::START_MARKER_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                rfd_pkg::REG_TYPE_MASK:    r_type_mask    <= pwdata;
                rfd_pkg::REG_PAD_BYTE:     r_pad_byte     <= pwdata[7:0];
                rfd_pkg::REG_START_MARKER: r_start_marker <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            rfd_pkg::REG_TYPE_MASK:    prdata = r_type_mask;
            rfd_pkg::REG_PAD_BYTE:     prdata = {56'd0, r_pad_byte};
            rfd_pkg::REG_START_MARKER: prdata = {56'd0, r_start_marker};
            default:                   prdata = '0;
        endcase
    end

    // input stage
    logic        r_s1_valid;
    logic [1:0]  r_s1_func;
    logic [7:0]  r_s1_byte;
    logic        r_s1_first;
    logic        r_s1_last;
    logic        r_s1_idx_ok;
    logic [7:0]  rd_data;

    // deframer state
    t_fill             r_fill, n_fill;
    logic              r_done, n_done;
    t_phase            r_phase, n_phase;
    rfd_pkg::t_status  r_pend, n_pend;
    logic [31:0]       r_resync, n_resync;
    logic [3:0][7:0]   r_hdr, n_hdr;

    // result register
    logic              r_o_valid;
    rfd_pkg::t_status  r_o_status;
    logic [7:0]        r_o_type;
    logic [7:0]        r_o_flags;
    logic [10:0]       r_o_len;
    logic [7:0]        r_o_rdata;
    logic [31:0]       r_o_resync;

    logic              accept;
    logic              s1_go;
    logic              has_res;
    logic              out_free;
    logic              push_go;
    logic              resync_hit;
    logic              starts;
    t_fill             pin_fill;
    t_fill             wofs;
    t_push             pr;
    rfd_pkg::t_status  res_status;
    rfd_pkg::t_status  emit_status;
    logic              emit_hdr;
    logic              mem_we;
    logic [16:0]       ridx_ext;

    always_comb begin
        has_res = (r_s1_func == rfd_pkg::FN_RAW) || (r_s1_func == rfd_pkg::FN_READ) ||
                  ((r_s1_func == rfd_pkg::FN_REPORT) && r_s1_last);
    end

    assign out_free = !r_o_valid || !i_stall;
    assign s1_go    = r_s1_valid && (!has_res || out_free);
    assign o_stall  = r_s1_valid && !s1_go;
    assign accept   = i_valid && !o_stall;
    assign ridx_ext = 17'(i_read_index);

    assign starts   = (r_s1_byte == r_start_marker);
    assign pin_fill = ((r_s1_func == rfd_pkg::FN_RAW) && r_done) ? '0 : r_fill;
    assign pr       = push_byte(pin_fill, r_hdr, r_s1_byte, r_type_mask, r_pad_byte);

    always_comb begin
        n_fill     = r_fill;
        n_done     = r_done;
        n_phase    = r_phase;
        n_pend     = r_pend;
        n_hdr      = r_hdr;
        push_go    = 1'b0;
        resync_hit = 1'b0;
        res_status = rfd_pkg::ST_AGAIN;
        unique case (r_s1_func)
            rfd_pkg::FN_REPORT: begin
                if (r_s1_first) begin
                    if (r_done) begin
                        n_done = 1'b0;
                        n_fill = '0;
                    end
                    n_pend  = rfd_pkg::ST_AGAIN;
                    n_phase = PH_NORMAL;
                    if (starts && (n_fill != '0)) begin
                        n_fill     = '0;
                        resync_hit = 1'b1;
                    end else if (!starts && (n_fill == '0)) begin
                        resync_hit = 1'b1;
                        n_phase    = PH_SKIP;
                    end
                end else begin
                    unique case (r_phase)
                        PH_NORMAL: begin
                            push_go = 1'b1;
                            n_fill  = pr.fill;
                            n_hdr   = pr.hdr;
                            if (pr.set_done) begin
                                n_done = 1'b1;
                            end
                            if (pr.rc == rfd_pkg::ST_OK) begin
                                n_pend  = rfd_pkg::ST_OK;
                                n_phase = PH_TAIL;
                            end else if (pr.rc != rfd_pkg::ST_AGAIN) begin
                                n_pend  = pr.rc;
                                n_phase = PH_SKIP;
                            end
                        end
                        PH_TAIL: begin
                            if (r_s1_byte != r_pad_byte) begin
                                n_fill     = '0;
                                n_done     = 1'b0;
                                resync_hit = 1'b1;
                                n_pend     = rfd_pkg::ST_AGAIN;
                                n_phase    = PH_SKIP;
                            end
                        end
                        default: ;
                    endcase
                end
                if (r_s1_last) begin
                    res_status = n_pend;
                    n_pend     = rfd_pkg::ST_AGAIN;
                    n_phase    = PH_NORMAL;
                end
            end
            rfd_pkg::FN_RAW: begin
                push_go    = 1'b1;
                n_fill     = pr.fill;
                n_hdr      = pr.hdr;
                n_done     = pr.set_done;
                res_status = pr.rc;
            end
            rfd_pkg::FN_READ: begin
                res_status = rfd_pkg::ST_READ;
            end
            default: ;
        endcase
        n_resync = (resync_hit && (r_resync != '1)) ? r_resync + 32'd1 : r_resync;
    end

    assign emit_hdr    = (res_status == rfd_pkg::ST_OK) && n_done;
    assign emit_status = ((res_status == rfd_pkg::ST_OK) && !n_done) ? rfd_pkg::ST_AGAIN
                                                                       : res_status;

    assign wofs   = pin_fill - t_fill'(HDR);
    assign mem_we = s1_go && push_go && pr.wr && (32'(pin_fill) >= 32'(HDR));

    rfd_store #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wofs[AW-1:0]),
        .i_wdata (r_s1_byte),
        .i_re    (accept),
        .i_raddr (ridx_ext[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fill     <= '0;
            r_done     <= 1'b0;
            r_phase    <= PH_NORMAL;
            r_pend     <= rfd_pkg::ST_AGAIN;
            r_resync   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid  <= 1'b1;
                r_s1_func   <= i_func;
                r_s1_byte   <= i_data_byte;
                r_s1_first  <= i_first_of_report;
                r_s1_last   <= i_last_of_report;
                r_s1_idx_ok <= (ridx_ext < 17'(MAX_PAYLOAD));
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_fill   <= n_fill;
                r_done   <= n_done;
                r_phase  <= n_phase;
                r_pend   <= n_pend;
                r_resync <= n_resync;
                r_hdr    <= n_hdr;
            end
            if (s1_go && has_res) begin
                r_o_valid  <= 1'b1;
                r_o_status <= emit_status;
                r_o_type   <= emit_hdr ? n_hdr[0] : 8'd0;
                r_o_flags  <= emit_hdr ? n_hdr[1] : 8'd0;
                r_o_len    <= emit_hdr ? {n_hdr[3][2:0], n_hdr[2]} : 11'd0;
                r_o_rdata  <= ((res_status == rfd_pkg::ST_READ) && r_s1_idx_ok) ? rd_data
                                                                                 : 8'd0;
                r_o_resync <= n_resync;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_frame_type     = r_o_type;
    assign o_frame_flags    = r_o_flags;
    assign o_payload_length = r_o_len;
    assign o_read_data      = r_o_rdata;
    assign o_resync_count   = r_o_resync;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("input stalled with the stage empty");

    a_read_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rfd_pkg::ST_READ)) |->
        ((o_frame_type == 8'd0) && (o_frame_flags == 8'd0) && (o_payload_length == 11'd0)))
        else $error("read result carries header fields");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(STORE_SIZE))
        else $error("fill count beyond the store");

    a_ok_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rfd_pkg::ST_OK)) |->
        (32'(o_payload_length) <= 32'(MAX_PAYLOAD)))
        else $error("completed frame longer than the limit");

    a_tail_pending_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TAIL) |-> (r_pend == rfd_pkg::ST_OK))
        else $error("tail phase without a pending good frame");

endmodule
